// ===== hw/rtl/ptt_pkg.sv =====
package ptt_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int ID_W        = 16;
    localparam int PER_W       = 16;
    localparam int MODE_W      = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK = 2'd0,
        MODE_SET  = 2'd1,
        MODE_KILL = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  ident;
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] count;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    typedef struct packed {
        logic            push;
        logic            flush;
        logic [ID_W-1:0] id;
    } out_ctl_t;

    typedef struct packed {
        logic room;
        logic pend_valid;
    } out_sts_t;

endpackage

// ===== hw/rtl/ptt_slot_ram.sv =====
module ptt_slot_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/ptt_out_stage.sv =====
module ptt_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ptt_pkg::out_ctl_t     ctl,
    output ptt_pkg::out_sts_t     sts,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [ptt_pkg::ID_W-1:0] fired_id,
    output logic                  last
);

    logic                     out_valid_reg, out_valid_next;
    logic [ptt_pkg::ID_W-1:0] out_id_reg, out_id_next;
    logic                     out_last_reg, out_last_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [ptt_pkg::ID_W-1:0] pend_id_reg, pend_id_next;
    logic                     out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // pending word waits until we know whether it is the last one
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        if (ctl.push)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_id_next    = pend_id_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_id_next    = ctl.id;
        end
        else if (ctl.flush && pend_valid_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_id_next     = pend_id_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_id_reg   <= out_id_next;
        out_last_reg <= out_last_next;
        pend_id_reg  <= pend_id_next;
    end

    assign sts.room       = !pend_valid_reg || out_free;
    assign sts.pend_valid = pend_valid_reg;
    assign out_valid      = out_valid_reg;
    assign fired_id       = out_id_reg;
    assign last           = out_last_reg;

endmodule

// ===== hw/rtl/periodic_timer_table.sv =====
// set: written straight into the first free slot
// tick and kill: a walk of the slot memory, one slot per cycle through its single read port
//   (a tick holds its slot while the output side has no room; kill ends early at the first match)
// throughput: one tick or kill per walk, longer while the output side stalls
// reset empties the table by clearing the per-slot used bits; the memory itself is not cleared
module periodic_timer_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [ptt_pkg::MODE_W-1:0]  mode,
    input  logic [ptt_pkg::ID_W-1:0]    timer_id,
    input  logic [ptt_pkg::PER_W-1:0]   period,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ptt_pkg::ID_W-1:0]    fired_id,
    output logic                        last
);

    localparam logic [ptt_pkg::SLOT_W-1:0] LAST_SLOT =
        ptt_pkg::SLOT_W'(ptt_pkg::TIMER_SLOTS - 1);
    localparam logic [ptt_pkg::RES_W-1:0] RES_MAX =
        ptt_pkg::RES_W'(ptt_pkg::MAX_RESULTS);

    ptt_pkg::state_t                  state_reg, state_next;
    logic                             kill_reg, kill_next;
    logic [ptt_pkg::ID_W-1:0]         id_reg, id_next;
    logic [ptt_pkg::SLOT_W-1:0]       idx_reg, idx_next;
    logic [ptt_pkg::RES_W-1:0]        n_reg, n_next;
    logic [ptt_pkg::TIMER_SLOTS-1:0]  used_reg, used_next;

    logic                             accept;
    logic                             free_found;
    logic [ptt_pkg::SLOT_W-1:0]       free_idx;
    ptt_pkg::slot_entry_t             rd_entry, wr_entry;
    logic [ptt_pkg::ENTRY_W-1:0]      rd_word;
    logic                             we;
    logic [ptt_pkg::SLOT_W-1:0]       waddr, raddr;
    logic [ptt_pkg::PER_W-1:0]        cnt_inc;
    logic                             slot_used, kill_hit, fire, report, advance, last_slot;
    ptt_pkg::out_ctl_t                octl;
    ptt_pkg::out_sts_t                osts;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ptt_pkg::ST_IDLE);
    assign rd_entry = ptt_pkg::slot_entry_t'(rd_word);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ptt_pkg::TIMER_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = ptt_pkg::SLOT_W'(i);
            end
        end
    end

    // slot decode for the walk
    always_comb
    begin
        slot_used = used_reg[idx_reg];
        cnt_inc   = rd_entry.count + ptt_pkg::PER_W'(1);
        kill_hit  = slot_used && (rd_entry.ident == id_reg);
        fire      = slot_used && (rd_entry.period != '0) && (cnt_inc == rd_entry.period);
        report    = fire && (n_reg < RES_MAX);
        last_slot = (idx_reg == LAST_SLOT);
        advance   = kill_reg || !report || osts.room;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                if (accept && (mode == ptt_pkg::MODE_TICK || mode == ptt_pkg::MODE_KILL))
                begin
                    state_next = ptt_pkg::ST_WALK;
                end
            end
            ptt_pkg::ST_WALK:
            begin
                if (kill_reg)
                begin
                    if (kill_hit || last_slot)
                    begin
                        state_next = ptt_pkg::ST_IDLE;
                    end
                end
                else if (advance && last_slot)
                begin
                    state_next = ptt_pkg::ST_FLUSH;
                end
            end
            ptt_pkg::ST_FLUSH:
            begin
                if (!osts.pend_valid)
                begin
                    state_next = ptt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kill_next  = kill_reg;
        id_next    = id_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        used_next  = used_reg;
        we         = 1'b0;
        waddr      = idx_reg;
        wr_entry   = rd_entry;
        raddr      = '0;
        octl.push  = 1'b0;
        octl.flush = 1'b0;
        octl.id    = rd_entry.ident;
        unique case (state_reg)
            ptt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kill_next = (mode == ptt_pkg::MODE_KILL);
                    id_next   = timer_id;
                    idx_next  = '0;
                    n_next    = '0;
                    if (mode == ptt_pkg::MODE_SET && free_found)
                    begin
                        we                  = 1'b1;
                        waddr               = free_idx;
                        wr_entry.ident      = timer_id;
                        wr_entry.period     = period;
                        wr_entry.count      = '0;
                        used_next[free_idx] = 1'b1;
                    end
                end
            end
            ptt_pkg::ST_WALK:
            begin
                raddr = advance ? idx_reg + ptt_pkg::SLOT_W'(1) : idx_reg;
                if (advance)
                begin
                    idx_next = idx_reg + ptt_pkg::SLOT_W'(1);
                end
                if (kill_reg)
                begin
                    if (kill_hit)
                    begin
                        used_next[idx_reg] = 1'b0;
                    end
                end
                else if (slot_used && advance)
                begin
                    we             = 1'b1;
                    wr_entry.count = fire ? '0 : cnt_inc;
                    if (report)
                    begin
                        octl.push = 1'b1;
                        n_next    = n_reg + ptt_pkg::RES_W'(1);
                    end
                end
            end
            ptt_pkg::ST_FLUSH:
            begin
                octl.flush = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptt_pkg::ST_IDLE;
            used_reg  <= '0;
            kill_reg  <= 1'b0;
            idx_reg   <= '0;
            n_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            kill_reg  <= kill_next;
            idx_reg   <= idx_next;
            n_reg     <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    ptt_slot_ram #(
        .DEPTH (ptt_pkg::TIMER_SLOTS),
        .WIDTH (ptt_pkg::ENTRY_W),
        .AW    (ptt_pkg::SLOT_W)
    ) u_slot_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wr_entry),
        .raddr (raddr),
        .rdata (rd_word)
    );

    ptt_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (octl),
        .sts       (osts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .fired_id  (fired_id),
        .last      (last)
    );

    // a word is only pushed when the output side has room for it
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        octl.push |-> osts.room)
        else $error("push without room in output stage");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= RES_MAX)
        else $error("result count overflow");

    // set or kill changes at most one used bit per cycle
    a_used_one: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(used_reg ^ $past(used_reg)) <= 1)
        else $error("more than one slot changed");

    // nothing is left pending once the walk is over
    a_idle_flushed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptt_pkg::ST_IDLE) |-> !osts.pend_valid)
        else $error("pending word left after walk");

    // a walk step that holds keeps its slot
    a_hold_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ptt_pkg::ST_WALK && !advance) |=> $stable(idx_reg))
        else $error("slot index moved while held");

endmodule
